[sv/epsar_pkg.sv]
// Shared widths, register indexes, reset values and mode codes for the ESC pulse ramp unit.
package epsar_pkg;

  localparam int PULSE_W    = 12;
  localparam int CMD_W      = 11;
  localparam int STEP_W     = 8;
  localparam int Q_BITS     = 10;
  localparam int PROD_W     = PULSE_W + CMD_W;
  localparam int TGT_W      = PULSE_W + 2;
  localparam int CALC_W     = PULSE_W + 4;
  localparam int IO_LANES   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [PULSE_W-1:0] PULSE_LIMIT = '1;

  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2000;
  localparam logic [STEP_W-1:0]  SLEW_RST      = 8'd20;
  localparam logic [STEP_W-1:0]  ARM_STEP_RST  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_MIN = 2'd0,
    REG_PULSE_MAX = 2'd1,
    REG_SLEW_STEP = 2'd2,
    REG_ARM_STEP  = 2'd3
  } cfg_reg_t;

  // {motors_on, armed}
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'b00,
    MODE_DISARM = 2'b01,
    MODE_ARM    = 2'b10,
    MODE_FLY    = 2'b11
  } mode_t;

endpackage

[sv/esc_pulse_slew_arm_ramp_unit.sv]
// Top level: ESC pulse setpoints with slew limit and arming/disarming ramp.
//
// channel | dir | handshake          | beat contents
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// in      | in  | in_valid/in_ready  | motors_on, throttle_a..d (Q10)
// out     | out | out_valid/out_ready| pulse_a..d, update_mask, armed_now
//
// Two register stages: the throttle targets (one 12x11 multiply per lane) are
// registered, then setpoint update and clamp load the state and output register.
// One beat per cycle is sustained while out_ready is high.
// in_ready stays high while out_ready is high; a stalled output holds one beat
// plus one beat in the target stage. Synchronous reset clears setpoints,
// armed flag and loads the register defaults.
module esc_pulse_slew_arm_ramp_unit #(
  parameter int MOTORS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [epsar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epsar_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_motors_on,
  input  logic [epsar_pkg::CMD_W-1:0]        in_throttle_a,
  input  logic [epsar_pkg::CMD_W-1:0]        in_throttle_b,
  input  logic [epsar_pkg::CMD_W-1:0]        in_throttle_c,
  input  logic [epsar_pkg::CMD_W-1:0]        in_throttle_d,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [epsar_pkg::PULSE_W-1:0]      out_pulse_a,
  output logic [epsar_pkg::PULSE_W-1:0]      out_pulse_b,
  output logic [epsar_pkg::PULSE_W-1:0]      out_pulse_c,
  output logic [epsar_pkg::PULSE_W-1:0]      out_pulse_d,
  output logic [epsar_pkg::IO_LANES-1:0]     out_update_mask,
  output logic                               out_armed_now
);
  import epsar_pkg::*;

  logic [PULSE_W-1:0] pmin_r, pmax_r;
  logic [STEP_W-1:0]  slew_r, arm_r;

  logic               s1_valid_r;
  logic               s1_on_r;
  logic [TGT_W-1:0]   s1_tgt_r [MOTORS];
  logic [TGT_W-1:0]   tgt      [MOTORS];

  logic [PULSE_W-1:0] sp_r     [MOTORS];
  logic [PULSE_W-1:0] sp_nxt   [MOTORS];
  logic               armed_r;
  logic               armed_nxt;

  logic [MOTORS-1:0]  lane_mask;
  logic [MOTORS-1:0]  below;
  logic [MOTORS-1:0]  keep;

  logic                    out_valid_r;
  logic [PULSE_W-1:0]      out_pulse_r [IO_LANES];
  logic [PULSE_W-1:0]      pulse_nxt   [IO_LANES];
  logic [IO_LANES-1:0]     out_mask_r, mask_nxt, present_mask;
  logic                    out_armed_r;

  logic [CMD_W-1:0]   in_cmd [IO_LANES];
  logic [PULSE_W-1:0] span;
  logic               in_take;
  logic               adv;
  mode_t              mode;

  assign in_cmd[0] = in_throttle_a;
  assign in_cmd[1] = in_throttle_b;
  assign in_cmd[2] = in_throttle_c;
  assign in_cmd[3] = in_throttle_d;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_take  = in_valid && in_ready;
  assign span     = (pmax_r >= pmin_r) ? (pmax_r - pmin_r) : '0;
  assign mode     = mode_t'({s1_on_r, armed_r});

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmin_r <= PULSE_MIN_RST;
      pmax_r <= PULSE_MAX_RST;
      slew_r <= SLEW_RST;
      arm_r  <= ARM_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PULSE_MIN: pmin_r <= cfg_data[PULSE_W-1:0];
        REG_PULSE_MAX: pmax_r <= cfg_data[PULSE_W-1:0];
        REG_SLEW_STEP: slew_r <= cfg_data[STEP_W-1:0];
        REG_ARM_STEP:  arm_r  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < MOTORS; g++) begin : g_lane
    logic [PROD_W-1:0]        prod;
    logic signed [CALC_W-1:0] delta, lim, dl, v, lo_s, hi_s;
    logic [PULSE_W:0]         arm_sum;
    logic [PULSE_W-1:0]       sp, fly_v, arm_v, dis_v;
    logic                     lt_arm;

    if (g < IO_LANES) begin : g_cmd
      assign prod = span * in_cmd[g];
    end else begin : g_nocmd
      assign prod = '0;
    end
    assign tgt[g] = TGT_W'(pmin_r) + TGT_W'(prod[PROD_W-1:Q_BITS]);

    always_comb begin
      sp     = sp_r[g];
      lo_s   = $signed(CALC_W'(pmin_r));
      hi_s   = $signed(CALC_W'(pmax_r));
      delta  = $signed(CALC_W'(s1_tgt_r[g])) - $signed(CALC_W'(sp));
      lim    = $signed(CALC_W'(slew_r));
      if (delta > lim) dl = lim;
      else if (delta < -lim) dl = -lim;
      else dl = delta;
      v = $signed(CALC_W'(sp)) + dl;
      if (v > hi_s) v = hi_s;
      if (v < lo_s) v = lo_s;
      fly_v = v[PULSE_W-1:0];

      arm_sum = {1'b0, sp} + (PULSE_W+1)'(arm_r);
      arm_v   = arm_sum[PULSE_W] ? PULSE_LIMIT : arm_sum[PULSE_W-1:0];

      lt_arm = sp < PULSE_W'(arm_r);
      dis_v  = lt_arm ? '0 : sp - PULSE_W'(arm_r);

      below[g]     = sp < pmin_r;
      keep[g]      = 1'b0;
      lane_mask[g] = 1'b0;
      sp_nxt[g]    = sp;
      unique case (mode)
        MODE_FLY: begin
          sp_nxt[g]    = fly_v;
          lane_mask[g] = fly_v != sp;
        end
        MODE_ARM: begin
          if (below[g]) begin
            sp_nxt[g]    = arm_v;
            lane_mask[g] = 1'b1;
          end
        end
        MODE_DISARM: begin
          if (sp != '0) begin
            sp_nxt[g]    = dis_v;
            lane_mask[g] = 1'b1;
            keep[g]      = !lt_arm;
          end
        end
        MODE_IDLE: ;
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (in_take) s1_tgt_r[g] <= tgt[g];
      if (!rst_n) sp_r[g] <= '0;
      else if (adv) sp_r[g] <= sp_nxt[g];
    end
  end

  always_comb begin
    unique case (mode)
      MODE_FLY:    armed_nxt = 1'b1;
      MODE_ARM:    armed_nxt = !(|below);
      MODE_DISARM: armed_nxt = |keep;
      MODE_IDLE:   armed_nxt = 1'b0;
      default:     armed_nxt = 1'b0;
    endcase
  end

  for (genvar j = 0; j < IO_LANES; j++) begin : g_out
    if (j < MOTORS) begin : g_present
      assign present_mask[j] = 1'b1;
      assign pulse_nxt[j]    = (mode == MODE_IDLE) ? '0 : sp_nxt[j];
      assign mask_nxt[j]     = (mode == MODE_IDLE) ? 1'b1 : lane_mask[j];
    end else begin : g_absent
      assign present_mask[j] = 1'b0;
      assign pulse_nxt[j]    = '0;
      assign mask_nxt[j]     = present_mask[j];
    end
    always_ff @(posedge clk) begin
      if (adv) out_pulse_r[j] <= pulse_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      armed_r     <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) begin
        out_valid_r <= 1'b1;
        armed_r     <= armed_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_on_r <= in_motors_on;
    if (adv) begin
      out_mask_r  <= mask_nxt;
      out_armed_r <= armed_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pulse_a     = out_pulse_r[0];
  assign out_pulse_b     = out_pulse_r[1];
  assign out_pulse_c     = out_pulse_r[2];
  assign out_pulse_d     = out_pulse_r[3];
  assign out_update_mask = out_mask_r;
  assign out_armed_now   = out_armed_r;

endmodule

[sv/epsar_chk.sv]
// Port-level checker for the ESC pulse ramp unit, bound to the top level.
module epsar_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [epsar_pkg::PULSE_W-1:0]      out_pulse_a,
  input logic [epsar_pkg::PULSE_W-1:0]      out_pulse_b,
  input logic [epsar_pkg::PULSE_W-1:0]      out_pulse_c,
  input logic [epsar_pkg::PULSE_W-1:0]      out_pulse_d,
  input logic [epsar_pkg::IO_LANES-1:0]     out_update_mask,
  input logic                               out_armed_now
);
  import epsar_pkg::*;

  // beats accepted but not yet delivered
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_a) && $stable(out_pulse_b)
      && $stable(out_pulse_c) && $stable(out_pulse_d) && $stable(out_update_mask)
      && $stable(out_armed_now))
    else $error("stalled output beat changed");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // both stages full: a new beat only enters while the output drains
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3 && (pend_r != 2'd2 || !in_ready || out_ready))
    else $error("more beats in flight than stages");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without input beat");

endmodule

bind esc_pulse_slew_arm_ramp_unit epsar_chk u_epsar_chk (.*);
